// File: rtl/pshr_pkg.sv
// Shared types, constants and tables for the phase shifter / hilbert rotator.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package pshr_pkg;

  // delay line and hilbert filter geometry
  localparam int LINE_LEN     = 65;
  localparam int LINE_MID     = LINE_LEN / 2;
  localparam int HIL_TAPS     = (LINE_MID + 1) / 2;
  localparam int LINE_AW      = $clog2(LINE_LEN);
  localparam int CORDIC_ITERS = 20;
  localparam int MUL_STEPS    = 8;
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

  // configuration register indexes
  localparam logic [3:0] CFG_REAL_MODE    = 4'd0;
  localparam logic [3:0] CFG_USE_CONTROL  = 4'd1;
  localparam logic [3:0] CFG_FIXED_PHASE  = 4'd2;
  localparam logic [3:0] CFG_SENSITIVITY  = 4'd3;
  localparam logic [3:0] CFG_QUANT_MODE   = 4'd4;
  localparam logic [3:0] CFG_NUM_BITS     = 4'd5;
  localparam logic [3:0] CFG_PHASE_OFFSET = 4'd6;
  localparam logic [3:0] CFG_GAIN         = 4'd7;

  typedef struct packed {
    logic               real_mode;
    logic               use_control;
    logic [15:0]        fixed_phase;
    logic signed [15:0] sensitivity;
    logic               quant_mode;
    logic [4:0]         num_bits;
    logic [15:0]        phase_offset;
    logic [15:0]        gain;
  } cfg_t;

  // one item between front and back
  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic [15:0]        phase;
  } work_t;

  // one finished result
  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic [15:0]        phase;
  } res_t;

  // cordic angle table, 2^32 per turn
  function automatic logic [29:0] cordic_atan(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2607;
      5'd19: v = 30'd1303;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // hilbert taps for odd offsets m = 2j+1, 2/pi at 2^30 divided by m
  function automatic logic [29:0] hil_coef(input logic [3:0] j);
    logic [29:0] v;
    case (j)
      4'd0:  v = 30'd683565276;
      4'd1:  v = 30'd227855092;
      4'd2:  v = 30'd136713055;
      4'd3:  v = 30'd97652182;
      4'd4:  v = 30'd75951697;
      4'd5:  v = 30'd62142298;
      4'd6:  v = 30'd52581944;
      4'd7:  v = 30'd45571018;
      4'd8:  v = 30'd40209722;
      4'd9:  v = 30'd35977120;
      4'd10: v = 30'd32550727;
      4'd11: v = 30'd29720229;
      4'd12: v = 30'd27342611;
      4'd13: v = 30'd25317232;
      4'd14: v = 30'd23571216;
      4'd15: v = 30'd22050493;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // clamp to a 16-bit signed sample
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767)       r = 16'sh7FFF;
    else if (v < -40'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pshr_queue.sv
// Two-entry queue of work items between the front and the back.
// Depends on pshr_pkg for the item type.
`default_nettype none

module pshr_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  pshr_pkg::work_t     push_data,
  output logic                q_full,
  input  wire                 pop,
  output logic                q_empty,
  output pshr_pkg::work_t     pop_data
);

  pshr_pkg::work_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign q_full   = (cnt_r == 2'd2);
  assign q_empty  = (cnt_r == 2'd0);
  assign do_push  = push && !q_full;
  assign do_pop   = pop && !q_empty;
  assign pop_data = ent_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

// File: rtl/pshr_front.sv
// Front end: accepts items, forms the control phase, quantises and offsets it.
// Depends on pshr_pkg; feeds pshr_queue.
`default_nettype none

module pshr_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pshr_pkg::cfg_t      cfg,
  input  wire                 push,
  output logic                full,
  input  wire  signed [15:0]  in_sample_i,
  input  wire  signed [15:0]  in_sample_q,
  input  wire  signed [15:0]  in_control_volts,
  output logic                q_push,
  input  wire                 q_full,
  output pshr_pkg::work_t     q_data
);

  logic               v_r;
  logic signed [31:0] prod_r;
  logic signed [15:0] si_r, sq_r;
  logic               accept;
  logic [31:0]        rnd;
  logic [15:0]        ph_src, ph_q, ph_fin, qmask;
  logic [4:0]         sh;
  logic [16:0]        half, qsum;
  logic               do_quant;

  assign full   = v_r && q_full;
  assign accept = push && !full;
  assign q_push = v_r;

  // control phase: (sens * volts + 2048) >> 12, wrapped to 16 bits
  assign rnd    = prod_r + 32'sd2048;
  assign ph_src = cfg.use_control ? rnd[27:12] : cfg.fixed_phase;

  // half-up rounding to 2^num_bits steps
  assign do_quant = cfg.quant_mode && (cfg.num_bits != 5'd0) && (cfg.num_bits < 5'd16);
  assign sh       = 5'd16 - cfg.num_bits;
  assign half     = 17'd1 << (sh - 5'd1);
  assign qsum     = {1'b0, ph_src} + half;
  assign qmask    = 16'hFFFF << sh;
  assign ph_q     = do_quant ? (qsum[15:0] & qmask) : ph_src;
  assign ph_fin   = ph_q + cfg.phase_offset;

  assign q_data.sample_i = si_r;
  assign q_data.sample_q = sq_r;
  assign q_data.phase    = ph_fin;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (!q_full) begin
      v_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= cfg.sensitivity * in_control_volts;
      si_r   <= in_sample_i;
      sq_r   <= in_sample_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pshr_back.sv
// Back end: cordic cos/sin, hilbert filter over the delay line, rotation, gain
// and the result queue. Depends on pshr_pkg; fed from pshr_queue.
`default_nettype none

module pshr_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pshr_pkg::cfg_t      cfg,
  input  wire                 q_empty,
  output logic                q_pop,
  input  pshr_pkg::work_t     q_data,
  output logic                empty,
  input  wire                 pop,
  output pshr_pkg::res_t      res
);

  typedef enum logic [2:0] {S_IDLE, S_ROT, S_TRIG, S_HIL, S_MUL, S_OUT} state_t;

  localparam logic [4:0] ROT_LAST = 5'(pshr_pkg::CORDIC_ITERS - 1);
  localparam logic [4:0] HIL_MIDR = 5'(pshr_pkg::HIL_TAPS);
  localparam logic [4:0] HIL_LAST = 5'(pshr_pkg::HIL_TAPS + 2);
  localparam logic [4:0] MUL_LAST = 5'(pshr_pkg::MUL_STEPS - 1);
  localparam int AW = pshr_pkg::LINE_AW;

  state_t     state_r;
  logic [4:0] it_r;

  // item registers
  logic signed [15:0] si_r, sq_r, cos_r, sin_r, mid_r;
  logic [15:0]        ph_r;
  logic               flip_r;
  logic signed [32:0] x_r, y_r, z_r;

  // delay line
  logic signed [15:0]     dline_mem [pshr_pkg::LINE_LEN];
  logic [pshr_pkg::LINE_LEN-1:0] dline_vld_r;
  logic [AW-1:0]          wp_r, base_r, addr_a, addr_b;
  logic signed [15:0]     rda_raw_r, rdb_raw_r, rda, rdb;
  logic                   va_r, vb_r;
  logic                   rd_tap_v_r, rd_mid_r, prod_v_r;
  logic [3:0]             rd_j_r;
  logic signed [47:0]     hprod_r;
  logic signed [51:0]     hacc_r, hacc_rnd;
  logic signed [19:0]     hil_r;
  logic [6:0]             k_a, k_b, m_off;

  // multiply steps
  logic signed [19:0] ma;
  logic signed [16:0] mb;
  logic signed [36:0] mprod;
  logic signed [37:0] acc_i_r, acc_q_r;
  logic signed [55:0] fin_i_r, fin_q_r, fin_i_rnd, fin_q_rnd;

  // cordic step signals
  logic [15:0]        ph_in, ph_fl;
  logic               flip_in;
  logic signed [32:0] dx, dy, at, x_f, y_f;
  logic signed [33:0] x_rnd, y_rnd;

  // result queue
  pshr_pkg::res_t res_r [2];
  pshr_pkg::res_t res_new;
  logic           owp_r, orp_r;
  logic [1:0]     ocnt_r;
  logic           opush, opop;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [6:0] k);
    logic signed [8:0] t;
    t = $signed({2'b00, b}) - $signed({2'b00, k});
    if (t < 0) t = t + 9'(pshr_pkg::LINE_LEN);
    return t[AW-1:0];
  endfunction

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // phase folding into the cordic range
  assign ph_in   = q_data.phase;
  assign flip_in = ph_in[15] ^ ph_in[14];
  assign ph_fl   = flip_in ? (ph_in ^ 16'h8000) : ph_in;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = $signed({3'b000, pshr_pkg::cordic_atan(it_r)});
  assign x_f   = flip_r ? -x_r : x_r;
  assign y_f   = flip_r ? -y_r : y_r;
  assign x_rnd = {x_f[32], x_f} + 34'sd16384;
  assign y_rnd = {y_f[32], y_f} + 34'sd16384;

  // delay line addresses: delays LINE_MID +/- m, then the centre tap
  assign m_off  = {2'b00, it_r[3:0], 1'b1};
  assign k_a    = (it_r == HIL_MIDR) ? 7'(pshr_pkg::LINE_MID)
                                     : 7'(pshr_pkg::LINE_MID) + m_off;
  assign k_b    = 7'(pshr_pkg::LINE_MID) - m_off;
  assign addr_a = wrap(base_r, k_a);
  assign addr_b = wrap(base_r, k_b);
  assign rda    = va_r ? rda_raw_r : 16'sd0;
  assign rdb    = vb_r ? rdb_raw_r : 16'sd0;
  assign hacc_rnd = hacc_r + 52'sd536870912;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (it_r[2:0])
      3'd0: begin
        ma = cfg.real_mode ? {{4{mid_r[15]}}, mid_r} : {{4{si_r[15]}}, si_r};
        mb = {cos_r[15], cos_r};
      end
      3'd1: begin
        ma = cfg.real_mode ? hil_r : {{4{sq_r[15]}}, sq_r};
        mb = {sin_r[15], sin_r};
      end
      3'd2: begin
        ma = {{4{si_r[15]}}, si_r};
        mb = {sin_r[15], sin_r};
      end
      3'd3: begin
        ma = {{4{sq_r[15]}}, sq_r};
        mb = {cos_r[15], cos_r};
      end
      3'd4: begin
        ma = {2'b00, acc_i_r[17:0]};
        mb = {1'b0, cfg.gain};
      end
      3'd5: begin
        ma = acc_i_r[37:18];
        mb = {1'b0, cfg.gain};
      end
      3'd6: begin
        ma = {2'b00, acc_q_r[17:0]};
        mb = {1'b0, cfg.gain};
      end
      3'd7: begin
        ma = acc_q_r[37:18];
        mb = {1'b0, cfg.gain};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign mprod = ma * mb;

  // final rounding to Q1.15
  assign fin_i_rnd     = fin_i_r + 56'sd536870912;
  assign fin_q_rnd     = fin_q_r + 56'sd536870912;
  assign res_new.out_i = pshr_pkg::sat16({{14{fin_i_rnd[55]}}, fin_i_rnd[55:30]});
  assign res_new.out_q = cfg.real_mode ? 16'sd0
                       : pshr_pkg::sat16({{14{fin_q_rnd[55]}}, fin_q_rnd[55:30]});
  assign res_new.phase = ph_r;

  assign opush = (state_r == S_OUT) && (ocnt_r != 2'd2);
  assign empty = (ocnt_r == 2'd0);
  assign opop  = pop && !empty;
  assign res   = res_r[orp_r];

  // sequencer, delay line valid bits and result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      it_r        <= 5'd0;
      wp_r        <= '0;
      dline_vld_r <= '0;
      rd_tap_v_r  <= 1'b0;
      rd_mid_r    <= 1'b0;
      prod_v_r    <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      owp_r       <= 1'b0;
      orp_r       <= 1'b0;
      ocnt_r      <= 2'd0;
    end else begin
      rd_tap_v_r <= (state_r == S_HIL) && (it_r < HIL_MIDR);
      rd_mid_r   <= (state_r == S_HIL) && (it_r == HIL_MIDR);
      prod_v_r   <= rd_tap_v_r;
      va_r       <= dline_vld_r[addr_a];
      vb_r       <= dline_vld_r[addr_b];
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            state_r <= S_ROT;
            it_r    <= 5'd0;
            if (cfg.real_mode) begin
              dline_vld_r[wp_r] <= 1'b1;
              wp_r <= (wp_r == AW'(pshr_pkg::LINE_LEN - 1)) ? '0 : wp_r + 1'b1;
            end
          end
        end
        S_ROT: begin
          if (it_r == ROT_LAST) state_r <= S_TRIG;
          else                  it_r    <= it_r + 5'd1;
        end
        S_TRIG: begin
          it_r    <= 5'd0;
          state_r <= cfg.real_mode ? S_HIL : S_MUL;
        end
        S_HIL: begin
          if (it_r == HIL_LAST) begin
            it_r    <= 5'd0;
            state_r <= S_MUL;
          end else begin
            it_r <= it_r + 5'd1;
          end
        end
        S_MUL: begin
          if (it_r == MUL_LAST) state_r <= S_OUT;
          else                  it_r    <= it_r + 5'd1;
        end
        S_OUT: begin
          if (opush) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (opush) owp_r <= ~owp_r;
      if (opop)  orp_r <= ~orp_r;
      if (opush && !opop)      ocnt_r <= ocnt_r + 2'd1;
      else if (opop && !opush) ocnt_r <= ocnt_r - 2'd1;
    end
  end

  // delay line memory, two registered read ports
  always_ff @(posedge clk) begin
    if (q_pop && cfg.real_mode) dline_mem[wp_r] <= q_data.sample_i;
    rda_raw_r <= dline_mem[addr_a];
    rdb_raw_r <= dline_mem[addr_b];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      si_r   <= q_data.sample_i;
      sq_r   <= q_data.sample_q;
      ph_r   <= q_data.phase;
      base_r <= wp_r;
      flip_r <= flip_in;
      x_r    <= pshr_pkg::CORDIC_K;
      y_r    <= '0;
      z_r    <= {ph_fl[15], ph_fl, 16'h0000};
    end
    if (state_r == S_ROT) begin
      if (!z_r[32]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (state_r == S_TRIG) begin
      cos_r  <= pshr_pkg::sat16({{21{x_rnd[33]}}, x_rnd[33:15]});
      sin_r  <= pshr_pkg::sat16({{21{y_rnd[33]}}, y_rnd[33:15]});
      hacc_r <= '0;
    end
    // hilbert pipeline: read, multiply, accumulate
    if (rd_tap_v_r)
      hprod_r <= $signed({1'b0, pshr_pkg::hil_coef(rd_j_r)})
               * ($signed({rda[15], rda}) - $signed({rdb[15], rdb}));
    if (rd_mid_r) mid_r <= rda;
    if (prod_v_r) hacc_r <= hacc_r + {{4{hprod_r[47]}}, hprod_r};
    rd_j_r <= it_r[3:0];
    if (state_r == S_HIL && it_r == HIL_LAST) hil_r <= hacc_rnd[49:30];
    // rotation and gain steps
    if (state_r == S_MUL) begin
      case (it_r[2:0])
        3'd0: acc_i_r <= {mprod[36], mprod};
        3'd1: acc_i_r <= acc_i_r - {mprod[36], mprod};
        3'd2: acc_q_r <= {mprod[36], mprod};
        3'd3: acc_q_r <= acc_q_r + {mprod[36], mprod};
        3'd4: fin_i_r <= {{19{mprod[36]}}, mprod};
        3'd5: fin_i_r <= fin_i_r + ({{19{mprod[36]}}, mprod} <<< 18);
        3'd6: fin_q_r <= {{19{mprod[36]}}, mprod};
        3'd7: fin_q_r <= fin_q_r + ({{19{mprod[36]}}, mprod} <<< 18);
        default: acc_i_r <= acc_i_r;
      endcase
    end
    if (opush) res_r[owp_r] <= res_new;
  end

`ifndef SYNTHESIS
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3) else $error("result queue count out of range");
  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (it_r <= ROT_LAST)) else $error("cordic step overrun");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_ROT && it_r == 5'd0)) else $error("item taken but not started");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    opush |=> (state_r == S_IDLE && !empty)) else $error("result not queued");
`endif

endmodule

`default_nettype wire

// File: rtl/phase_shifter_hilbert_rotator.sv
// Top level of the phase shifter / hilbert rotator: configuration registers,
// front end, work queue and back end. Depends on pshr_pkg and all pshr_ modules.
`default_nettype none

// Rotates I/Q samples (complex mode) or a real stream through a 65-tap hilbert
// filter (real mode) by a phase from fixed_phase or sensitivity * control volts,
// optionally rounded to 2^num_bits steps and offset, then scales by gain and
// saturates. Items are taken through a queue-like push/full port and results
// leave through empty/pop. The back end handles one item at a time with the
// 20-step shared cordic, in real mode a hilbert pass over the delay line (two
// read ports) and eight steps of one shared multiplier. Up to two items wait
// between front and back, so the input only stalls when these fill. The delay
// line starts at zero after reset and only advances in real mode. Registers
// are written through cfg_we, cfg_index and cfg_wdata while no item is in
// flight; the user must keep to this, the block itself does not enforce it.
module phase_shifter_hilbert_rotator (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  wire  signed [15:0]  in_sample_i,
  input  wire  signed [15:0]  in_sample_q,
  input  wire  signed [15:0]  in_control_volts,
  output logic                empty,
  input  wire                 pop,
  output logic signed [15:0]  out_i,
  output logic signed [15:0]  out_q,
  output logic [15:0]         out_applied_phase,
  input  wire                 cfg_we,
  input  wire  [3:0]          cfg_index,
  input  wire  [15:0]         cfg_wdata
);

  pshr_pkg::cfg_t  cfg_r;
  pshr_pkg::work_t fq_data, bq_data;
  pshr_pkg::res_t  res;
  logic            fq_push, fq_full, bq_pop, bq_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.real_mode    <= 1'b0;
      cfg_r.use_control  <= 1'b0;
      cfg_r.fixed_phase  <= 16'd0;
      cfg_r.sensitivity  <= 16'sd16384;
      cfg_r.quant_mode   <= 1'b0;
      cfg_r.num_bits     <= 5'd6;
      cfg_r.phase_offset <= 16'd0;
      cfg_r.gain         <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        pshr_pkg::CFG_REAL_MODE:    cfg_r.real_mode    <= cfg_wdata[0];
        pshr_pkg::CFG_USE_CONTROL:  cfg_r.use_control  <= cfg_wdata[0];
        pshr_pkg::CFG_FIXED_PHASE:  cfg_r.fixed_phase  <= cfg_wdata;
        pshr_pkg::CFG_SENSITIVITY:  cfg_r.sensitivity  <= cfg_wdata;
        pshr_pkg::CFG_QUANT_MODE:   cfg_r.quant_mode   <= cfg_wdata[0];
        pshr_pkg::CFG_NUM_BITS:     cfg_r.num_bits     <= cfg_wdata[4:0];
        pshr_pkg::CFG_PHASE_OFFSET: cfg_r.phase_offset <= cfg_wdata;
        pshr_pkg::CFG_GAIN:         cfg_r.gain         <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // phase front end
  pshr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .push             (push),
    .full             (full),
    .in_sample_i      (in_sample_i),
    .in_sample_q      (in_sample_q),
    .in_control_volts (in_control_volts),
    .q_push           (fq_push),
    .q_full           (fq_full),
    .q_data           (fq_data)
  );

  // work queue
  pshr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .q_full    (fq_full),
    .pop       (bq_pop),
    .q_empty   (bq_empty),
    .pop_data  (bq_data)
  );

  // rotation back end
  pshr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (bq_empty),
    .q_pop   (bq_pop),
    .q_data  (bq_data),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_i             = res.out_i;
  assign out_q             = res.out_q;
  assign out_applied_phase = res.phase;

endmodule

`default_nettype wire
